>>> sv/bba_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the buddy block allocator.
package bba_pkg;

  localparam int TOP_BLOCKS      = 32;
  localparam int TOP_ORDER       = 10;
  localparam int MIN_BLOCK_BYTES = 128;
  localparam int MIN_SHIFT       = 7;
  localparam int GRANULES        = TOP_BLOCKS << TOP_ORDER;
  localparam int GW              = 15;   // granule index width
  localparam int CW              = 16;   // counter width, holds GRANULES itself
  localparam int BW              = 18;   // block byte size width
  localparam int SW              = 23;   // byte sum width
  localparam logic [BW-1:0] TOP_BYTES = BW'(MIN_BLOCK_BYTES << TOP_ORDER);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_TOO_BIG  = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic       head;
    logic       free;
    logic [3:0] ord;
  } entry_t;

  typedef struct packed {
    logic          we;
    logic [GW-1:0] waddr;
    entry_t        wdata;
    logic [GW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [21:0]   offset;
    logic [3:0]    order;
    logic [CW-1:0] free_cnt;
    logic [CW-1:0] all_cnt;
    logic [SW-1:0] size_sum;
  } res_t;

  function automatic logic [BW-1:0] block_bytes(input logic [3:0] ord);
    block_bytes = BW'(MIN_BLOCK_BYTES) << ord;
  endfunction

  // Smallest order whose block, less the header, holds the size.
  function automatic logic [3:0] pick_order(input logic [17:0] size, input logic [6:0] hdr);
    logic [3:0]    res;
    logic [BW-1:0] bs;
    logic          fits;
    res = 4'(TOP_ORDER);
    for (int k = TOP_ORDER; k >= 0; k--) begin
      bs = block_bytes(4'(k));
      if (bs > BW'(hdr)) begin
        fits = ({1'b0, size} + 19'(hdr)) <= {1'b0, bs};
      end else begin
        fits = (size == '0);
      end
      if (fits) begin
        res = 4'(k);
      end
    end
    return res;
  endfunction

endpackage

>>> sv/buddy_block_allocator.sv
`timescale 1ns / 1ps
// Buddy block allocator over 32 top blocks of 128 KiB, orders 0 to 10; one beat in flight.
// Steps to m_axis_tvalid, output free: alloc walks the block heads, then splits down to
//   the wanted order; no free block walks the heads only; too large goes straight out; free
//   checks the entry, then merges with free buddies up to the top order; bad offset goes out at once.
// The next beat is taken only once the sequencer is back in idle after its result leaves.
// Reset: a clearing pass rewrites the whole table with input held off; header 56.
module buddy_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,      // header_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,     // request_bytes[17:0], free_offset[39:18]
  input  logic [0:0]  s_axis_tuser,     // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,     // block_offset[21:0], block_order[25:22],
                                        // free_block_count[41:26],
                                        // total_block_count[57:42],
                                        // free_payload_bytes[80:58], zeros above
  output logic [1:0]  m_axis_tuser      // status
);
  import bba_pkg::*;

  logic [6:0] hdr_q;
  mem_req_t   mem_req;
  entry_t     mem_rdata;
  logic       res_valid, res_ready;
  res_t       res;
  logic [SW-1:0] sub, payload;
  logic [87:0] tdata_q;
  logic [1:0]  tuser_q;
  logic        out_valid_q;

  // Hold the header size; the user must write it only while idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= 7'd56;
    end else if (cfg_we_i) begin
      hdr_q <= cfg_wdata_i;
    end
  end

  bba_table u_table (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser[0]),
    .size_i      (s_axis_tdata[17:0]),
    .offset_i    (s_axis_tdata[39:18]),
    .hdr_i       (hdr_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_o       (mem_req),
    .rdata_i     (mem_rdata)
  );

  // Free payload: byte sum less one header per free block, floored at zero.
  assign sub = SW'(res.free_cnt) * SW'(hdr_q);
  assign payload = (res.size_sum > sub) ? (res.size_sum - sub) : '0;

  // Output register: advance when empty or when the current beat is taken.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      tdata_q <= {7'd0, payload, res.all_cnt, res.free_cnt, res.order, res.offset};
      tuser_q <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  // Rejected requests carry no block.
  a_reject_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_TOO_BIG || m_axis_tuser == ST_IGNORED ||
                      m_axis_tuser == ST_NO_FREE) |-> m_axis_tdata[25:0] == '0)
    else $error("rejected request reports a block");

  // Free blocks never outnumber all blocks.
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[41:26] <= m_axis_tdata[57:42])
    else $error("free count above total count");

  // Never take a new beat while a result still waits inside the sequencer.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !res_valid)
    else $error("input ready with result pending");

  // Reported order never exceeds the top order.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[25:22] <= 4'(TOP_ORDER))
    else $error("order out of range");

endmodule

>>> sv/bba_table.sv
`timescale 1ns / 1ps
// Granule table: one write port, one read port with registered read data.
module bba_table (
  input  logic               clk_i,
  input  bba_pkg::mem_req_t  req_i,
  output bba_pkg::entry_t    rdata_o
);
  import bba_pkg::*;

  entry_t mem [GRANULES];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

>>> sv/bba_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: clear pass, head walk, split, free check and buddy merge.
module bba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [17:0]      size_i,
  input  logic [21:0]      offset_i,
  input  logic [6:0]       hdr_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output bba_pkg::res_t    res_o,
  output bba_pkg::mem_req_t mem_o,
  input  bba_pkg::entry_t  rdata_i
);
  import bba_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_SPLIT = 4'd3;
  localparam logic [3:0] S_FCHK  = 4'd4;
  localparam logic [3:0] S_MISS  = 4'd5;
  localparam logic [3:0] S_MCHK  = 4'd6;
  localparam logic [3:0] S_FWR   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] g_q, g_d;
  logic [GW-1:0] best_q, best_d;
  logic [3:0]    bord_q, bord_d;
  logic          found_q, found_d;
  logic [3:0]    want_q, want_d;
  logic [3:0]    k_q, k_d;
  logic [CW-1:0] free_q, free_d;
  logic [CW-1:0] all_q, all_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [1:0]    st_q, st_d;
  logic [21:0]   off_q, off_d;
  logic [3:0]    ord_q, ord_d;

  logic [CW-1:0] next_g;
  logic          hit, better;
  logic [GW-1:0] bud, lo, hi;

  always_comb begin
    state_d = state_q; g_d = g_q; best_d = best_q; bord_d = bord_q; found_d = found_q;
    want_d = want_q; k_d = k_q; free_d = free_q; all_d = all_q; sum_d = sum_q;
    st_d = st_q; off_d = off_q; ord_d = ord_q;
    mem_o = '0;
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;
    next_g = g_q + (CW'(1) << rdata_i.ord);
    hit = rdata_i.head && rdata_i.free && (rdata_i.ord >= want_q);
    better = hit && (!found_q || (rdata_i.ord < bord_q));
    bud = g_q[GW-1:0] ^ (GW'(1) << k_q);
    lo = (g_q[GW-1:0] < bud) ? g_q[GW-1:0] : bud;
    hi = (g_q[GW-1:0] < bud) ? bud : g_q[GW-1:0];
    case (state_q)
      S_CLEAR: begin
        mem_o.we = 1'b1;
        mem_o.waddr = g_q[GW-1:0];
        if (g_q[TOP_ORDER-1:0] == '0) begin
          mem_o.wdata = '{head: 1'b1, free: 1'b1, ord: 4'(TOP_ORDER)};
        end
        g_d = g_q + CW'(1);
        if (g_q == CW'(GRANULES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        mem_o.raddr = (op_i == OP_FREE) ? offset_i[21:MIN_SHIFT] : '0;
        if (in_valid_i) begin
          off_d = '0;
          ord_d = '0;
          if (op_i == OP_ALLOC) begin
            want_d = pick_order(size_i, hdr_i);
            g_d = '0;
            found_d = 1'b0;
            if (size_i > TOP_BYTES) begin
              st_d = ST_TOO_BIG;
              state_d = S_OUT;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            g_d = CW'(offset_i[21:MIN_SHIFT]);
            if (offset_i[MIN_SHIFT-1:0] != '0) begin
              st_d = ST_IGNORED;
              state_d = S_OUT;
            end else begin
              state_d = S_FCHK;
            end
          end
        end
      end
      S_SCAN: begin
        // walk block heads; each read address follows from the order just read
        mem_o.raddr = next_g[GW-1:0];
        g_d = next_g;
        if (better) begin
          found_d = 1'b1;
          best_d = g_q[GW-1:0];
          bord_d = rdata_i.ord;
        end
        if ((better && rdata_i.ord == want_q) || next_g[GW]) begin
          if (better || found_q) begin
            free_d = free_q - CW'(1);
            sum_d = sum_q - SW'(block_bytes(better ? rdata_i.ord : bord_q));
            k_d = better ? rdata_i.ord : bord_q;
            state_d = S_SPLIT;
          end else begin
            st_d = ST_NO_FREE;
            state_d = S_OUT;
          end
        end
      end
      S_SPLIT: begin
        mem_o.we = 1'b1;
        if (k_q > want_q) begin
          mem_o.waddr = best_q ^ (GW'(1) << (k_q - 4'd1));
          mem_o.wdata = '{head: 1'b1, free: 1'b1, ord: k_q - 4'd1};
          all_d = all_q + CW'(1);
          free_d = free_q + CW'(1);
          sum_d = sum_q + SW'(block_bytes(k_q - 4'd1));
          k_d = k_q - 4'd1;
        end else begin
          mem_o.waddr = best_q;
          mem_o.wdata = '{head: 1'b1, free: 1'b0, ord: want_q};
          st_d = ST_OK;
          off_d = {best_q, MIN_SHIFT'(0)};
          ord_d = want_q;
          state_d = S_OUT;
        end
      end
      S_FCHK: begin
        if (!rdata_i.head || rdata_i.free) begin
          st_d = ST_IGNORED;
          state_d = S_OUT;
        end else begin
          k_d = (rdata_i.ord > 4'(TOP_ORDER)) ? 4'(TOP_ORDER) : rdata_i.ord;
          free_d = free_q + CW'(1);
          sum_d = sum_q + SW'(block_bytes(k_d));
          state_d = S_MISS;
        end
      end
      S_MISS: begin
        mem_o.raddr = bud;
        state_d = (k_q < 4'(TOP_ORDER)) ? S_MCHK : S_FWR;
      end
      S_MCHK: begin
        if (rdata_i.head && rdata_i.free && rdata_i.ord == k_q) begin
          mem_o.we = 1'b1;
          mem_o.waddr = hi;
          g_d = CW'(lo);
          k_d = k_q + 4'd1;
          free_d = free_q - CW'(1);
          all_d = all_q - CW'(1);
          state_d = S_MISS;
        end else begin
          state_d = S_FWR;
        end
      end
      S_FWR: begin
        mem_o.we = 1'b1;
        mem_o.waddr = g_q[GW-1:0];
        mem_o.wdata = '{head: 1'b1, free: 1'b1, ord: k_q};
        st_d = ST_OK;
        off_d = {g_q[GW-1:0], MIN_SHIFT'(0)};
        ord_d = k_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o = '{status: st_q, offset: off_q, order: ord_q,
                   free_cnt: free_q, all_cnt: all_q, size_sum: sum_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      g_q     <= '0;
      found_q <= 1'b0;
      free_q  <= CW'(TOP_BLOCKS);
      all_q   <= CW'(TOP_BLOCKS);
      sum_q   <= SW'(TOP_BLOCKS * (MIN_BLOCK_BYTES << TOP_ORDER));
    end else begin
      state_q <= state_d;
      g_q     <= g_d;
      found_q <= found_d;
      free_q  <= free_d;
      all_q   <= all_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    bord_q <= bord_d;
    want_q <= want_d;
    k_q    <= k_d;
    st_q   <= st_d;
    off_q  <= off_d;
    ord_q  <= ord_d;
  end

endmodule
